### design/sst_pkg.sv
package sst_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int KEY_W    = 32;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 5;

    typedef logic [TYPE_W-1:0] req_type_t;

    localparam req_type_t REQ_INSERT = 2'd0;
    localparam req_type_t REQ_DELETE = 2'd1;
    localparam req_type_t REQ_SEARCH = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } ctrl_state_t;

    // scan phase: looking for the slot, shifting up, shifting down, no more writes
    typedef enum logic [1:0] {
        PH_SEEK,
        PH_INS,
        PH_DEL,
        PH_HOLD
    } scan_phase_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

### design/sst_if.sv
interface sst_req_if;
    import sst_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [TYPE_W-1:0]       req_type;
    logic signed [KEY_W-1:0] key_value;

    modport source (output valid, req_type, key_value, input ready);
    modport sink   (input valid, req_type, key_value, output ready);
endinterface

interface sst_rsp_if;
    import sst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [ENTRY_W-1:0]  entry_count;

    modport source (output valid, status, found, entry_count, input ready);
    modport sink   (input valid, status, found, entry_count, output ready);
endinterface

### design/sorted_set_table_unit.sv
// channel | dir | beat contents
// req     | in  | req_type, key_value
// rsp     | out | status, found, entry_count
//
// A request runs in steps: a load step, then one stored entry per cycle through the single
// read port of the entry memory with shifting in flight, then a drain of the read, then a
// finish step.
// A new request is taken while the previous response beat still waits in the output register.
// A stalled rsp holds the finished request; the scan itself never stalls.
// Reset clears the count and the control state; no clearing pass over the entry memory.
module sorted_set_table_unit #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input logic      clk,
    input logic      rst_n,
    sst_req_if.sink  req,
    sst_rsp_if.source rsp
);
    import sst_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req.req_type),
        .key_value   (req.key_value),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .status      (rsp.status),
        .found       (rsp.found),
        .entry_count (rsp.entry_count)
    );

endmodule

### design/sst_ctrl.sv
module sst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sst_pkg::dp_stat_t stat,
    output sst_pkg::ctl_cmd_t cmd
);
    import sst_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = stat.out_free ? S_IDLE : S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                cmd.finish = stat.scan_done && stat.out_free;
            end
            S_WAIT:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/sst_dp.sv
module sst_dp #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sst_pkg::ctl_cmd_t               cmd,
    output sst_pkg::dp_stat_t               stat,
    input  logic [sst_pkg::TYPE_W-1:0]      req_type,
    input  logic signed [sst_pkg::KEY_W-1:0] key_value,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [sst_pkg::STATUS_W-1:0]    status,
    output logic                            found,
    output logic [sst_pkg::ENTRY_W-1:0]     entry_count
);
    import sst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic signed [KEY_W-1:0] mem [CAPACITY];

    logic signed [KEY_W-1:0] key_reg;
    req_type_t               op_reg;
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic signed [KEY_W-1:0] carry_reg;
    logic signed [KEY_W-1:0] carry_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic [CNT_W-1:0]        rd_idx_next;
    logic                    vld_reg;
    logic                    vld_next;
    logic                    hit_reg;
    logic                    hit_next;
    scan_phase_t             phase_reg;
    scan_phase_t             phase_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic                    found_reg;

    logic                    full;
    logic                    is_ins;
    logic                    is_del;
    logic                    rd_en;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_data;

    assign full   = (count_reg == CAP_CNT);
    assign is_ins = (op_reg == REQ_INSERT);
    assign is_del = (op_reg == REQ_DELETE);
    assign rd_en  = cmd.scan && (rd_idx_reg != count_reg);

    assign stat.scan_done = (rd_idx_reg == count_reg) && !vld_reg;
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    // one stored entry per cycle comes back from the read port
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = cmp_idx_reg;
        wr_data    = carry_reg;
        phase_next = phase_reg;
        carry_next = carry_reg;
        hit_next   = hit_reg;
        if (cmd.load)
        begin
            phase_next = PH_SEEK;
            hit_next   = 1'b0;
        end
        else if (cmd.scan && vld_reg)
        begin
            case (phase_reg)
                PH_SEEK:
                begin
                    if (rd_data_reg >= key_reg)
                    begin
                        if (rd_data_reg == key_reg)
                        begin
                            hit_next   = 1'b1;
                            phase_next = is_del ? PH_DEL : PH_HOLD;
                        end
                        else if (is_ins && !full)
                        begin
                            wr_en      = 1'b1;
                            wr_data    = key_reg;
                            carry_next = rd_data_reg;
                            phase_next = PH_INS;
                        end
                        else
                        begin
                            phase_next = PH_HOLD;
                        end
                    end
                end
                PH_INS:
                begin
                    wr_en      = 1'b1;
                    carry_next = rd_data_reg;
                end
                PH_DEL:
                begin
                    wr_en   = 1'b1;
                    wr_addr = cmp_idx_reg - IDX_W'(1);
                    wr_data = rd_data_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (cmd.finish && is_ins && !hit_reg && !full)
        begin
            // append at the tail: new key if it is the largest, else the last carried entry
            wr_addr = count_reg[IDX_W-1:0];
            if (phase_reg == PH_SEEK)
            begin
                wr_en   = 1'b1;
                wr_data = key_reg;
            end
            else if (phase_reg == PH_INS)
            begin
                wr_en = 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.load)
        begin
            rd_idx_next = '0;
        end
        else if (rd_en)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end
        vld_next = rd_en;
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        case (op_reg)
            REQ_INSERT:
            begin
                if (hit_reg)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DELETE:
            begin
                if (hit_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
        if (!cmd.finish)
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            vld_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            phase_reg     <= PH_SEEK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            vld_reg       <= vld_next;
            hit_reg       <= hit_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.load)
        begin
            key_reg <= key_value;
            op_reg  <= req_type;
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            found_reg  <= hit_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign entry_count = ENTRY_W'(count_reg);

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_rd_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> rd_idx_reg <= count_reg)
        else $error("scan index past entry count");

    a_finish_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid_reg)
        else $error("finished request without response beat");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && is_ins && !hit_reg && !full |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow table");

    a_del_hit: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DEL |-> hit_reg && is_del)
        else $error("delete shift without matching entry");
`endif

endmodule
